>>> hdl/pcsc_pkg.sv
`default_nettype none
package pcsc_pkg;

  localparam int DivBits = 16;

  typedef enum logic [1:0] {
    MODE_RGB_TO_HSV = 2'd0,
    MODE_HSV_TO_RGB = 2'd1,
    MODE_BIN_TO_RGB = 2'd2,
    MODE_UNUSED     = 2'd3
  } mode_t;

  // RGB to HSV uses the max channel codes, HSV to RGB the six hue sectors
  localparam logic [2:0] SecRed   = 3'd0;
  localparam logic [2:0] SecGreen = 3'd1;
  localparam logic [2:0] SecBlue  = 3'd2;
  localparam logic [2:0] Sec0     = 3'd0;
  localparam logic [2:0] Sec1     = 3'd1;
  localparam logic [2:0] Sec2     = 3'd2;
  localparam logic [2:0] Sec3     = 3'd3;
  localparam logic [2:0] Sec4     = 3'd4;
  localparam logic [2:0] Sec5     = 3'd5;

  typedef struct packed {
    mode_t      mode;
    logic [2:0] sec;
    logic       neg;
    logic [7:0] base;
    logic [7:0] mx;
    logic [7:0] mn;
    logic       zero_mx;
    logic       zero_d;
    logic       bin;
  } side_t;

  typedef struct packed {
    logic [DivBits-1:0] n;
    logic [7:0]         dv;
    logic [7:0]         r;
    logic [DivBits-1:0] q;
  } lane_t;

  typedef struct packed {
    logic  valid;
    side_t side;
    lane_t l0;
    lane_t l1;
  } item_t;

  // one restoring division step on dividend bit b
  function automatic lane_t div_step(lane_t x, logic [3:0] b);
    lane_t      y;
    logic [8:0] t;
    y = x;
    t = {x.r, x.n[b]};
    if (t >= {1'b0, x.dv}) begin
      y.r    = 8'(t - {1'b0, x.dv});
      y.q[b] = 1'b1;
    end else begin
      y.r = t[7:0];
    end
    return y;
  endfunction

endpackage
`default_nettype wire

>>> hdl/pcsc_prep.sv
`default_nettype none
module pcsc_prep import pcsc_pkg::*; (
  input  wire         clk,
  input  wire         rst,
  input  wire         en,
  input  wire         in_valid,
  input  wire  [7:0]  a,
  input  wire  [7:0]  b,
  input  wire  [7:0]  c,
  input  wire mode_t  mode,
  output item_t       out
);

  // first stage
  logic        v1;
  side_t       s1;
  logic [15:0] n0_1, p1;
  logic [7:0]  dv0_1, d1, adiff1;

  side_t       s1_next;
  logic [15:0] n0_next, p_next;
  logic [7:0]  adiff_next, mx, mn, d;
  logic [8:0]  diff;

  always_comb begin
    mx = a;
    if (b > mx) mx = b;
    if (c > mx) mx = c;
    mn = a;
    if (b < mn) mn = b;
    if (c < mn) mn = c;
    d = mx - mn;
    s1_next = '0;
    s1_next.mode = mode;
    s1_next.bin  = (a != 8'd0);
    n0_next = ({8'd0, d} << 8) - {8'd0, d};
    p_next  = {8'd0, b} * {8'd0, c};
    diff = '0;
    adiff_next = '0;
    if (mode == MODE_HSV_TO_RGB) begin
      s1_next.mx = c;
      priority if (a < 8'd30) begin
        s1_next.sec = Sec0; adiff_next = a;
      end else if (a < 8'd60) begin
        s1_next.sec = Sec1; adiff_next = 8'd60 - a;
      end else if (a < 8'd90) begin
        s1_next.sec = Sec2; adiff_next = a - 8'd60;
      end else if (a < 8'd120) begin
        s1_next.sec = Sec3; adiff_next = 8'd120 - a;
      end else if (a < 8'd150) begin
        s1_next.sec = Sec4; adiff_next = a - 8'd120;
      end else if (a <= 8'd180) begin
        s1_next.sec = Sec5; adiff_next = 8'd180 - a;
      end else begin
        // hue past 180 gives a negative term
        s1_next.sec = Sec5; adiff_next = a - 8'd180; s1_next.neg = 1'b1;
      end
    end else begin
      s1_next.mx      = mx;
      s1_next.mn      = mn;
      s1_next.zero_mx = (mx == 8'd0);
      s1_next.zero_d  = (d == 8'd0);
      priority if (mx == a) begin
        s1_next.sec  = SecRed;
        diff         = {1'b0, b} - {1'b0, c};
        s1_next.base = (b > c) ? 8'd0 : 8'd180;
      end else if (mx == b) begin
        s1_next.sec  = SecGreen;
        diff         = {1'b0, c} - {1'b0, a};
        s1_next.base = 8'd60;
      end else begin
        s1_next.sec  = SecBlue;
        diff         = {1'b0, a} - {1'b0, b};
        s1_next.base = 8'd120;
      end
      s1_next.neg = diff[8];
      adiff_next  = diff[8] ? 8'(-diff) : diff[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      s1     <= s1_next;
      n0_1   <= n0_next;
      dv0_1  <= mx;
      d1     <= d;
      adiff1 <= adiff_next;
      p1     <= p_next;
    end
  end

  // second stage: exact divide by 255 for products of two 8-bit values, then lane operands
  item_t       o_next;
  logic [16:0] p_sum;
  logic [7:0]  dd, hmn;

  always_comb begin
    p_sum = 17'(p1) + 17'(p1 >> 8) + 17'd1;
    dd    = p_sum[15:8];
    hmn   = s1.mx - dd;
    o_next = '0;
    o_next.valid = v1;
    o_next.side  = s1;
    o_next.l0.n  = n0_1;
    o_next.l0.dv = dv0_1;
    if (s1.mode == MODE_HSV_TO_RGB) begin
      o_next.side.mn   = hmn;
      o_next.side.base = hmn;
      o_next.l1.n      = {8'd0, adiff1} * {8'd0, dd};
      o_next.l1.dv     = 8'd30;
    end else begin
      o_next.l1.n  = {8'd0, adiff1} * 16'd30;
      o_next.l1.dv = d1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (en) begin
      out.valid <= o_next.valid;
    end
    if (en) begin
      out.side <= o_next.side;
      out.l0   <= o_next.l0;
      out.l1   <= o_next.l1;
    end
  end

endmodule
`default_nettype wire

>>> hdl/pcsc_div_cell.sv
`default_nettype none
module pcsc_div_cell import pcsc_pkg::*; #(
  parameter int BIT = 15
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        en,
  input  wire item_t in,
  output item_t      out
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (en) begin
      out.valid <= in.valid;
    end
    if (en) begin
      out.side <= in.side;
      out.l0   <= div_step(in.l0, 4'(BIT));
      out.l1   <= div_step(in.l1, 4'(BIT));
    end
  end

endmodule
`default_nettype wire

>>> hdl/pcsc_finish.sv
`default_nettype none
module pcsc_finish import pcsc_pkg::*; (
  input  wire         clk,
  input  wire         rst,
  input  wire         en,
  input  wire item_t  in,
  output logic        out_valid,
  output logic [23:0] out_data
);

  logic [7:0] o0, o1, o2, term, sum;
  side_t      s;

  always_comb begin
    s    = in.side;
    term = s.neg ? 8'(-in.l1.q[7:0]) : in.l1.q[7:0];
    sum  = s.base + term;
    o0 = '0; o1 = '0; o2 = '0;
    unique case (s.mode)
      MODE_RGB_TO_HSV: begin
        if (!s.zero_mx) begin
          o0 = s.zero_d ? 8'd0 : sum;
          o1 = in.l0.q[7:0];
          o2 = s.mx;
        end
      end
      MODE_HSV_TO_RGB: begin
        unique case (s.sec)
          Sec0:    begin o0 = s.mx; o1 = sum;  o2 = s.mn; end
          Sec1:    begin o0 = sum;  o1 = s.mx; o2 = s.mn; end
          Sec2:    begin o0 = s.mn; o1 = s.mx; o2 = sum;  end
          Sec3:    begin o0 = s.mn; o1 = sum;  o2 = s.mx; end
          Sec4:    begin o0 = sum;  o1 = s.mn; o2 = s.mx; end
          default: begin o0 = s.mx; o1 = s.mn; o2 = sum;  end
        endcase
      end
      MODE_BIN_TO_RGB: begin
        o0 = {8{s.bin}}; o1 = {8{s.bin}}; o2 = {8{s.bin}};
      end
      default: begin
        o0 = '0; o1 = '0; o2 = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in.valid;
    end
    if (en) begin
      out_data <= {o2, o1, o0};
    end
  end

endmodule
`default_nettype wire

>>> hdl/pixel_color_space_converter_top.sv
// channel   | dir | width | contents (low bit up)
// s_axis    | in  | 24    | chan_first, chan_second, chan_third
// m_axis    | out | 24    | out_first, out_second, out_third
// cfg       | in  | 2     | conversion_mode
//
// One pixel per clock unless the chain holds; the pipeline is two prep stages, a chain of
// 16 restoring divider cells (one quotient bit each, two lanes), one output stage.
// Synchronous active-high reset clears valid bits and the mode register.
// The whole chain holds while the output register is full and not taken.
`default_nettype none
module pixel_color_space_converter_top import pcsc_pkg::*; (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_wr_en,
  input  wire  [1:0]  cfg_wr_data,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [23:0] s_axis_tdata,   // chan_first, chan_second, chan_third
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [23:0] m_axis_tdata    // out_first, out_second, out_third
);

  mode_t mode;
  logic  en;
  item_t chain [DivBits+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_RGB_TO_HSV;
    end else if (cfg_wr_en) begin
      mode <= mode_t'(cfg_wr_data);
    end
  end

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  pcsc_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_axis_tvalid),
    .a        (s_axis_tdata[7:0]),
    .b        (s_axis_tdata[15:8]),
    .c        (s_axis_tdata[23:16]),
    .mode     (mode),
    .out      (chain[0])
  );

  for (genvar k = 0; k < DivBits; k++) begin : g_cell
    pcsc_div_cell #(.BIT(DivBits - 1 - k)) u_cell (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .in  (chain[k]),
      .out (chain[k+1])
    );
  end

  pcsc_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in        (chain[DivBits]),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata)
  );

`ifndef ASSERT_OFF
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && mode == MODE_RGB_TO_HSV |-> m_axis_tdata[7:0] <= 8'd180)
    else $error("hue out of range");
  a_bin_flat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && mode == MODE_BIN_TO_RGB |->
      (m_axis_tdata == 24'hFFFFFF || m_axis_tdata == 24'h000000))
    else $error("binary result not black or white");
  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && mode == MODE_UNUSED |-> m_axis_tdata == 24'h000000)
    else $error("unused mode gave nonzero result");
  a_val_max: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && mode == MODE_RGB_TO_HSV && m_axis_tdata[23:16] == 8'd0
      |-> m_axis_tdata[15:0] == 16'd0)
    else $error("zero value with nonzero hue or saturation");
`endif

endmodule
`default_nettype wire
